/* src/sukt_pkg.sv */
// Shared types, sizes and status codes of the sorted unique key table.
package sukt_pkg;

    localparam int DEPTH       = 64;
    localparam int MAX_RESULTS = 64;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUMPED    = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] key;
        logic [63:0]        name_tag;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry_key;
        logic [63:0]        entry_tag;
        logic [POS_W-1:0]   position;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        tag;
    } t_entry;

    typedef struct packed {
        logic   shift;
        t_entry entry;
    } t_ring;

endpackage

/* src/sukt_cell.sv */
// One storage cell of the entry ring, loading its neighbor's entry on each shift.
module sukt_cell import sukt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_next,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

/* src/sukt_ctrl.sv */
// Sequencer that rotates the ring, compares each head entry and forms the results.
module sukt_ctrl import sukt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_in    i_data,
    output logic   o_valid,
    input  logic   i_stall,
    output t_out   o_data,
    input  t_entry i_head,
    output t_ring  o_ring
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RES
    } t_state;

    t_state             r_state;
    logic               r_op;
    logic signed [31:0] r_key;
    logic [63:0]        r_tag;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_count;
    logic               r_done;
    logic               r_shift;
    t_entry             r_hold;
    t_out               r_res;
    logic               r_out_valid;
    t_out               r_out;

    logic can;
    logic step;
    logic last_step;
    logic hv;
    logic full;
    logic ge;
    logic eq;
    logic ins_hit;
    logic dup_hit;
    logic emit;
    logic dump_last;
    logic load_out;

    always_comb begin
        can       = !r_out_valid || !i_stall;
        step      = (r_state == S_SCAN) && ((r_op == OP_INSERT) || can);
        last_step = (r_idx == IDX_W'(DEPTH - 1));
        hv        = (CNT_W'(r_idx) < r_count);
        full      = (r_count == CNT_W'(DEPTH));
        ge        = hv && (i_head.key >= r_key);
        eq        = hv && (i_head.key == r_key);
        dup_hit   = step && (r_op == OP_INSERT) && !r_done && eq;
        ins_hit   = step && (r_op == OP_INSERT) && !r_done && !full && !eq && (!hv || ge);
        emit      = step && (r_op == OP_DUMP) && hv && (32'(r_idx) < MAX_RESULTS);
        dump_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count)
                    || (32'(r_idx) == MAX_RESULTS - 1);
        load_out  = emit || ((r_state == S_RES) && can);

        o_ring.shift = step;
        if (ins_hit) begin
            o_ring.entry.key = r_key;
            o_ring.entry.tag = r_tag;
        end else if ((r_op == OP_INSERT) && r_shift) begin
            o_ring.entry = r_hold;
        end else begin
            o_ring.entry = i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_shift     <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (can) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_data.operation;
                        r_key   <= i_data.key;
                        r_tag   <= i_data.name_tag;
                        r_idx   <= '0;
                        r_done  <= 1'b0;
                        r_shift <= 1'b0;
                        if ((i_data.operation == OP_DUMP) && (r_count == '0)) begin
                            r_res.status    <= ST_EMPTY;
                            r_res.entry_key <= '0;
                            r_res.entry_tag <= '0;
                            r_res.position  <= '0;
                            r_res.last      <= 1'b1;
                            r_state         <= S_RES;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (step) begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (emit) begin
                            r_out.status        <= ST_DUMPED;
                            r_out.entry_key     <= i_head.key;
                            r_out.entry_tag     <= i_head.tag;
                            r_out.position      <= POS_W'(r_idx);
                            r_out.last          <= dump_last;
                        end
                        if (ins_hit) begin
                            r_res.status    <= ST_INSERTED;
                            r_res.entry_key <= r_key;
                            r_res.entry_tag <= r_tag;
                            r_res.position  <= POS_W'(r_idx);
                            r_res.last      <= 1'b1;
                            r_done          <= 1'b1;
                            r_shift         <= 1'b1;
                        end
                        if (dup_hit) begin
                            r_res.status    <= ST_DUPLICATE;
                            r_res.entry_key <= r_key;
                            r_res.entry_tag <= i_head.tag;
                            r_res.position  <= POS_W'(r_idx);
                            r_res.last      <= 1'b1;
                            r_done          <= 1'b1;
                        end
                        if (ins_hit || r_shift) begin
                            r_hold <= i_head;
                        end
                        if (last_step) begin
                            if (r_op == OP_INSERT) begin
                                r_state <= S_RES;
                                if (!r_done && !ins_hit && !dup_hit) begin
                                    r_res.status    <= ST_FULL;
                                    r_res.entry_key <= r_key;
                                    r_res.entry_tag <= r_tag;
                                    r_res.position  <= '0;
                                    r_res.last      <= 1'b1;
                                end
                                if (ins_hit || r_shift) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_RES: begin
                    if (can) begin
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* src/sorted_unique_key_table.sv */
// Top level of the sorted unique key table: a ring of entry cells and its sequencer.
// Each transaction but an empty dump rotates the whole ring once, one cell per cycle through a single compare.
// An insert gives its one result through S_RES after the scan; no new transaction is taken before S_IDLE.
// A dump emits the entries in key order, one per scan step, at most MAX_RESULTS of them.
// An output stall on a dump pauses the ring; an empty dump answers through S_RES without a scan.
// Reset clears the entry count and the control state only; the cells get no clearing pass.
module sorted_unique_key_table import sukt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_entry cell_q [DEPTH];
    t_ring  ring;

    sukt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .i_head  (cell_q[0]),
        .o_ring  (ring)
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == DEPTH - 1) begin : g_tail
            sukt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (ring.shift),
                .i_next  (ring.entry),
                .o_entry (cell_q[k])
            );
        end else begin : g_body
            sukt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (ring.shift),
                .i_next  (cell_q[k+1]),
                .o_entry (cell_q[k])
            );
        end
    end

endmodule

/* src/sukt_checker.sv */
// Port checker for the sorted unique key table and its bind to the top level.
module sukt_checker import sukt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("Stalled result transaction changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Input accepted again right after a transaction.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= ST_EMPTY)
        else $error("Result status out of range.");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status != ST_DUMPED) |-> o_data.last)
        else $error("Single result transaction without last.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_EMPTY) |->
            (o_data.entry_key == '0) && (o_data.entry_tag == '0) && (o_data.position == '0))
        else $error("Empty dump result carries nonzero fields.");

endmodule

bind sorted_unique_key_table sukt_checker u_sukt_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the sorted unique key table: a directed table, then random traffic, checked against a predictor.
module tb;
    import sukt_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int RANDOM_ITEMS = 412;

    typedef struct {
        t_in  stim;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    logic signed [31:0] mirror_keys [DEPTH];
    logic [63:0]        mirror_tags [DEPTH];
    int                 mirror_count = 0;
    t_out               pending_results [$];
    t_row               rows [$];

    bit   cur_typed = 1'b0;
    t_out cur_want = '0;
    bit   quiet = 1'b0;
    int   stall_left = 0;
    int   cycles = 0;
    int   failures = 0;
    int   n_checked = 0;
    int   n_inserted = 0;
    int   n_duplicate = 0;
    int   n_full = 0;
    int   n_dumped = 0;
    int   n_empty = 0;
    int   n_dumps = 0;

    sorted_unique_key_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    function automatic t_out mk_out(logic [2:0] st, logic signed [31:0] k, logic [63:0] tg,
                                    int pos, logic lst);
        t_out r;
        r.status    = st;
        r.entry_key = k;
        r.entry_tag = tg;
        r.position  = pos[POS_W-1:0];
        r.last      = lst;
        return r;
    endfunction

    // Applies one accepted transaction to the mirrored table and queues the results it causes.
    task automatic apply_to_table(input t_in item);
        int idx;
        int emit;
        if (item.operation == OP_DUMP) begin
            n_dumps++;
            if (mirror_count == 0) begin
                pending_results.push_back(mk_out(ST_EMPTY, '0, '0, 0, 1'b1));
            end else begin
                emit = (mirror_count > MAX_RESULTS) ? MAX_RESULTS : mirror_count;
                for (idx = 0; idx < emit; idx++)
                    pending_results.push_back(mk_out(ST_DUMPED, mirror_keys[idx],
                        mirror_tags[idx], idx, idx == emit - 1));
            end
        end else begin
            idx = 0;
            while (idx < mirror_count && $signed(mirror_keys[idx]) < $signed(item.key))
                idx++;
            if (idx < mirror_count && mirror_keys[idx] == item.key) begin
                pending_results.push_back(mk_out(ST_DUPLICATE, item.key, mirror_tags[idx],
                    idx, 1'b1));
            end else if (mirror_count >= DEPTH) begin
                pending_results.push_back(mk_out(ST_FULL, item.key, item.name_tag, 0, 1'b1));
            end else begin
                for (int j = mirror_count; j > idx; j--) begin
                    mirror_keys[j] = mirror_keys[j-1];
                    mirror_tags[j] = mirror_tags[j-1];
                end
                mirror_keys[idx] = item.key;
                mirror_tags[idx] = item.name_tag;
                mirror_count++;
                pending_results.push_back(mk_out(ST_INSERTED, item.key, item.name_tag,
                    idx, 1'b1));
            end
        end
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [31:0] pick_key();
        int r;
        logic signed [31:0] k;
        r = $urandom_range(0, 99);
        if (mirror_count > 0 && r < 25)
            return mirror_keys[$urandom_range(0, mirror_count - 1)];
        if (mirror_count > 0 && r < 40) begin
            k = mirror_keys[$urandom_range(0, mirror_count - 1)];
            return ($urandom_range(0, 1) != 0) ? k + 32'sd1 : k - 32'sd1;
        end
        if (r < 46) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [63:0] pick_tag();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic add_row(logic op, logic signed [31:0] k, logic [63:0] tg, bit typed,
                           t_out want);
        t_row row;
        row.stim.operation = op;
        row.stim.key       = k;
        row.stim.name_tag  = tg;
        row.typed          = typed;
        row.want           = want;
        rows.push_back(row);
    endtask

    task automatic send_item(input t_in item, input bit typed, input t_out want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data    = item;
        cur_typed = typed;
        cur_want  = want;
        i_valid   = 1'b1;
        do
            @(posedge i_clk);
        while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
            if (i_rst_n && !quiet && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("cycle %0d: unexpected result status %0d key %0d",
                        cycles, o_data.status, o_data.entry_key));
                end else begin
                    exp_r = pending_results.pop_front();
                    case (exp_r.status)
                        ST_INSERTED:  n_inserted++;
                        ST_DUPLICATE: n_duplicate++;
                        ST_FULL:      n_full++;
                        ST_DUMPED:    n_dumped++;
                        default:      n_empty++;
                    endcase
                    if (o_data.status !== exp_r.status || o_data.entry_key !== exp_r.entry_key
                            || o_data.entry_tag !== exp_r.entry_tag
                            || o_data.position !== exp_r.position
                            || o_data.last !== exp_r.last)
                        note_failure($sformatf({"cycle %0d: expected st %0d key %0d tag %h ",
                            "pos %0d last %0b, got st %0d key %0d tag %h pos %0d last %0b"},
                            cycles, exp_r.status, exp_r.entry_key, exp_r.entry_tag,
                            exp_r.position, exp_r.last, o_data.status, o_data.entry_key,
                            o_data.entry_tag, o_data.position, o_data.last));
                end
            end
            if (i_valid && !o_stall) begin
                apply_to_table(i_data);
                if (cur_typed) begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(cur_want);
                end
            end
        end
    end

    initial begin
        t_in item;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_stall = 1'b0;

        add_row(OP_DUMP, '0, '0, 1'b1, mk_out(ST_EMPTY, '0, '0, 0, 1'b1));
        add_row(OP_INSERT, '0, 64'd1, 1'b1, mk_out(ST_INSERTED, '0, 64'd1, 0, 1'b1));
        add_row(OP_INSERT, 32'sh7fff_ffff, '1, 1'b1,
                mk_out(ST_INSERTED, 32'sh7fff_ffff, '1, 1, 1'b1));
        add_row(OP_INSERT, 32'sh8000_0000, '0, 1'b1,
                mk_out(ST_INSERTED, 32'sh8000_0000, '0, 0, 1'b1));
        add_row(OP_INSERT, -32'sd1, 64'ha5a5_a5a5_a5a5_a5a5, 1'b1,
                mk_out(ST_INSERTED, -32'sd1, 64'ha5a5_a5a5_a5a5_a5a5, 1, 1'b1));
        add_row(OP_INSERT, 32'sd1, 64'h0123_4567_89ab_cdef, 1'b1,
                mk_out(ST_INSERTED, 32'sd1, 64'h0123_4567_89ab_cdef, 3, 1'b1));
        add_row(OP_INSERT, 32'sh7fff_ffff, 64'h5, 1'b1,
                mk_out(ST_DUPLICATE, 32'sh7fff_ffff, '1, 4, 1'b1));
        add_row(OP_INSERT, 32'sh8000_0000, '1, 1'b1,
                mk_out(ST_DUPLICATE, 32'sh8000_0000, '0, 0, 1'b1));
        add_row(OP_DUMP, '0, '0, 1'b0, '0);
        add_row(OP_DUMP, 32'sh5a5a_5a5a, '1, 1'b0, '0);
        add_row(OP_INSERT, 32'sh8000_0001, 64'h1111, 1'b0, '0);
        add_row(OP_INSERT, 32'sh7fff_fffe, 64'h2222, 1'b0, '0);
        add_row(OP_INSERT, '0, 64'h3333, 1'b0, '0);
        add_row(OP_INSERT, 32'sh5555_5555, 64'h5555_5555_5555_5555, 1'b0, '0);
        add_row(OP_INSERT, 32'shaaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0);
        add_row(OP_INSERT, -32'sd2, 64'hfeed, 1'b0, '0);
        add_row(OP_DUMP, '0, '0, 1'b0, '0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[r])
            send_item(rows[r].stim, rows[r].typed, rows[r].want);

        // Inserts fill the table well before the end, so the later part works the full table.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet          = (n % 70) >= 55;
            item.operation = ($urandom_range(0, 99) < 9) ? OP_DUMP : OP_INSERT;
            item.key       = pick_key();
            item.name_tag  = pick_tag();
            send_item(item, 1'b0, '0);
        end
        i_valid = 1'b0;
        quiet   = 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);

        $display("covered %0d inserts, %0d duplicate refusals, %0d full-table refusals",
                 n_inserted, n_duplicate, n_full);
        $display("and %0d dumps with %0d entries and %0d empty answers; %0d results checked",
                 n_dumps, n_dumped, n_empty, n_checked);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures", failures);
            $display("status: fail");
        end
        $finish;
    end

endmodule
